>>> design/hstc_pkg.sv
package hstc_pkg;

	localparam logic [5:0] MAX_PREFIX_ZEROS = 6'd31;

	localparam logic [2:0] PH_HEADER    = 3'd0;
	localparam logic [2:0] PH_MB_PREFIX = 3'd1;
	localparam logic [2:0] PH_MB_SUFFIX = 3'd2;
	localparam logic [2:0] PH_ST_PREFIX = 3'd3;
	localparam logic [2:0] PH_ST_SUFFIX = 3'd4;
	localparam logic [2:0] PH_DONE      = 3'd5;

	localparam logic [1:0] CLASS_P = 2'd0;
	localparam logic [1:0] CLASS_B = 2'd1;
	localparam logic [1:0] CLASS_I = 2'd2;

	typedef struct packed {
		logic [2:0]  phase;
		logic [5:0]  zero_count;
		logic [5:0]  suffix_left;
		logic [31:0] suffix_value;
		logic [31:0] first_mb_value;
	} dec_state_t;

	typedef struct packed {
		logic        emit;
		logic [1:0]  frame_class;
		logic [31:0] slice_kind;
		logic [31:0] first_macroblock;
		logic        truncated;
	} dec_result_t;

	function automatic logic [1:0] classify(input logic [31:0] kind);
		logic [1:0] cls;
		case (kind)
			32'd1, 32'd6: cls = CLASS_B;
			32'd2, 32'd4, 32'd7, 32'd9: cls = CLASS_I;
			default: cls = CLASS_P;
		endcase
		return cls;
	endfunction

	function automatic logic [31:0] code_value(input logic [5:0] zc, input logic [31:0] sv);
		logic [32:0] base;
		base = (33'd1 << zc[4:0]) - 33'd1;
		return base[31:0] + sv;
	endfunction

endpackage

>>> design/hstc_step.sv
module hstc_step (
	input  hstc_pkg::dec_state_t  cur,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output hstc_pkg::dec_state_t  nxt,
	output hstc_pkg::dec_result_t res
);

	always_comb begin
		hstc_pkg::dec_state_t s;
		logic        emit;
		logic        trunc;
		logic [31:0] kind;
		logic [31:0] mb;
		logic [31:0] v;
		logic [2:0]  idx;
		logic        bit_v;
		logic        done_code;
		s = cur;
		emit = 1'b0;
		trunc = 1'b0;
		kind = '0;
		mb = '0;
		v = '0;
		idx = '0;
		bit_v = 1'b0;
		done_code = 1'b0;
		if (s.phase == hstc_pkg::PH_HEADER) begin
			s = '0;
			s.phase = hstc_pkg::PH_MB_PREFIX;
		end else begin
			for (int i = 0; i < 8; i++) begin
				idx = 3'(7 - i);
				bit_v = data_byte[idx];
				done_code = 1'b0;
				if (s.phase != hstc_pkg::PH_DONE) begin
					if (s.phase == hstc_pkg::PH_MB_PREFIX ||
					    s.phase == hstc_pkg::PH_ST_PREFIX) begin
						if (!bit_v) begin
							s.zero_count = s.zero_count + 6'd1;
							if (s.zero_count > hstc_pkg::MAX_PREFIX_ZEROS) begin
								emit = 1'b1;
								trunc = 1'b1;
								mb = (s.phase == hstc_pkg::PH_ST_PREFIX) ?
									s.first_mb_value : '0;
								s.phase = hstc_pkg::PH_DONE;
							end
						end else if (s.zero_count == 6'd0) begin
							s.suffix_value = '0;
							done_code = 1'b1;
						end else begin
							s.suffix_left = s.zero_count;
							s.suffix_value = '0;
							s.phase = (s.phase == hstc_pkg::PH_MB_PREFIX) ?
								hstc_pkg::PH_MB_SUFFIX : hstc_pkg::PH_ST_SUFFIX;
						end
					end else begin
						s.suffix_value = {s.suffix_value[30:0], bit_v};
						s.suffix_left = s.suffix_left - 6'd1;
						if (s.suffix_left == 6'd0) begin
							done_code = 1'b1;
						end
					end
					if (done_code) begin
						v = hstc_pkg::code_value(s.zero_count, s.suffix_value);
						if (s.phase == hstc_pkg::PH_MB_PREFIX ||
						    s.phase == hstc_pkg::PH_MB_SUFFIX) begin
							s.first_mb_value = v;
							s.zero_count = '0;
							s.suffix_value = '0;
							s.phase = hstc_pkg::PH_ST_PREFIX;
						end else begin
							emit = 1'b1;
							kind = v;
							mb = s.first_mb_value;
							s.phase = hstc_pkg::PH_DONE;
						end
					end
				end
			end
		end
		if (last_byte && !emit && s.phase != hstc_pkg::PH_DONE) begin
			emit = 1'b1;
			trunc = 1'b1;
			mb = (s.phase == hstc_pkg::PH_ST_PREFIX || s.phase == hstc_pkg::PH_ST_SUFFIX) ?
				s.first_mb_value : '0;
		end
		if (last_byte) begin
			s.phase = hstc_pkg::PH_HEADER;
		end
		nxt = s;
		res.emit = emit;
		res.frame_class = trunc ? hstc_pkg::CLASS_P : hstc_pkg::classify(kind);
		res.slice_kind = trunc ? '0 : kind;
		res.first_macroblock = mb;
		res.truncated = trunc;
	end

endmodule

>>> design/h264_slice_type_classifier_top.sv
// Accepts one NAL byte per clock cycle while in_ready is high; the first byte of a NAL is the
// header and is skipped, and each later byte has all eight bits decoded in that cycle. The
// classification appears in the result register in the cycle after the byte that completes the
// slice type, overruns the prefix cap, or ends the NAL early. A waiting result stalls input only
// when out_ready is low, since the result register frees as it is taken.
module h264_slice_type_classifier_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  frame_class,
	output logic [31:0] slice_kind,
	output logic [31:0] first_macroblock,
	output logic        truncated
);

	hstc_pkg::dec_state_t  state_q;
	hstc_pkg::dec_state_t  state_nxt;
	hstc_pkg::dec_result_t res;
	logic                  out_valid_q;
	logic [1:0]            frame_class_q;
	logic [31:0]           slice_kind_q;
	logic [31:0]           first_mb_q;
	logic                  truncated_q;
	logic                  accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	hstc_step u_step (
		.cur       (state_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept && res.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.emit) begin
			frame_class_q <= res.frame_class;
			slice_kind_q <= res.slice_kind;
			first_mb_q <= res.first_macroblock;
			truncated_q <= res.truncated;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_class = frame_class_q;
	assign slice_kind = slice_kind_q;
	assign first_macroblock = first_mb_q;
	assign truncated = truncated_q;

	a_last_to_header: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> state_q.phase == hstc_pkg::PH_HEADER)
		else $error("phase did not return to header after the last byte");

	a_emit_ends_nal: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.emit |=>
			state_q.phase == hstc_pkg::PH_DONE || state_q.phase == hstc_pkg::PH_HEADER)
		else $error("decoder kept decoding after a result");

	a_trunc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && truncated_q |-> frame_class_q == hstc_pkg::CLASS_P &&
			slice_kind_q == 32'd0)
		else $error("truncated result carries a slice type");

	a_suffix_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == hstc_pkg::PH_MB_SUFFIX || state_q.phase == hstc_pkg::PH_ST_SUFFIX
		|-> state_q.suffix_left != 6'd0)
		else $error("suffix phase with no suffix bits left");

	a_prefix_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != hstc_pkg::PH_DONE && state_q.phase != hstc_pkg::PH_HEADER |->
			state_q.zero_count <= hstc_pkg::MAX_PREFIX_ZEROS)
		else $error("prefix count passed the cap without truncation");

endmodule
